@@ rtl/core/zled_pkg.sv @@
// ----------------------------------------------------------------------------
// zled_pkg
// Shared codes, signatures and the result record of the ZIP local entry
// deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package zled_pkg;

  localparam logic [2:0] KIND_HEADER  = 3'd0;
  localparam logic [2:0] KIND_NAME    = 3'd1;
  localparam logic [2:0] KIND_PAYLOAD = 3'd2;
  localparam logic [2:0] KIND_END     = 3'd3;
  localparam logic [2:0] KIND_ERROR   = 3'd4;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_SIGNATURE = 3'd1;
  localparam logic [2:0] ERR_METHOD    = 3'd2;
  localparam logic [2:0] ERR_TRUNCATED = 3'd3;
  localparam logic [2:0] ERR_DEFL_DESC = 3'd4;

  localparam logic [31:0] SIG_LOCAL   = 32'h04034b50;
  localparam logic [31:0] SIG_CENTRAL = 32'h02014b50;
  localparam logic [31:0] SIG_DESC    = 32'h08074b50;

  localparam int unsigned FLAG_DESC_BIT = 3;
  localparam logic [15:0] METHOD_STORED = 16'd0;
  localparam logic [15:0] METHOD_DEFL   = 16'd8;

  typedef struct packed {
    logic        valid;
    logic [2:0]  kind;
    logic [2:0]  error_code;
    logic [7:0]  data;
    logic        last;
    logic [31:0] packed_size;
    logic [31:0] unpacked_size;
    logic        is_deflate;
    logic [15:0] name_length;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/core/zip_local_entry_deframer.sv @@
// ----------------------------------------------------------------------------
// zip_local_entry_deframer
// ZIP local entry deframer: header report, filename and payload forwarding.
// ----------------------------------------------------------------------------
// One archive byte is taken per cycle while in_ready is high, with at most one
// result word per byte; stream_end with no byte closes the stream. The parser
// state updates in the accept cycle and the result lands in a single output
// register, so in_ready stays high while that register is empty or being
// drained by out_ready; out_valid rises in the cycle after the accept. After
// an end-of-archive or error word, further input is consumed with no result.
`timescale 1ns / 1ps
`default_nettype none

module zip_local_entry_deframer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_stream_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_kind,
  output logic [2:0]       out_error_code,
  output logic [7:0]       out_byte,
  output logic             out_last_in_run,
  output logic [31:0]      out_packed_size,
  output logic [31:0]      out_unpacked_size,
  output logic             out_is_deflate,
  output logic [15:0]      out_name_length
);

  logic           take;
  zled_pkg::res_t res;
  zled_pkg::res_t res_r;
  logic           out_valid_r;

  assign in_ready = !out_valid_r || out_ready;
  assign take     = in_valid && in_ready;

  zled_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .take_i       (take),
    .data_byte_i  (in_data_byte),
    .stream_end_i (in_stream_end),
    .res_o        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= res.valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res.valid) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = res_r.kind;
  assign out_error_code    = res_r.error_code;
  assign out_byte          = res_r.data;
  assign out_last_in_run   = res_r.last;
  assign out_packed_size   = res_r.packed_size;
  assign out_unpacked_size = res_r.unpacked_size;
  assign out_is_deflate    = res_r.is_deflate;
  assign out_name_length   = res_r.name_length;

`ifndef SYNTH
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with empty output register");
  a_hold_unaccepted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(res_r))
    else $error("pending result word lost or changed");
  a_header_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind != zled_pkg::KIND_HEADER |-> out_name_length == 16'd0 &&
      out_packed_size == 32'd0 && out_unpacked_size == 32'd0)
    else $error("header fields set on non-header word");
`endif

endmodule

`default_nettype wire

@@ rtl/core/zled_parser.sv @@
// ----------------------------------------------------------------------------
// zled_parser
// Header capture and entry sequencing; at most one word per accept, result
// formed in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module zled_parser (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          take_i,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic          stream_end_i,
  output zled_pkg::res_t     res_o
);

  typedef enum logic [2:0] {
    PH_HDR,
    PH_NAME,
    PH_EXTRA,
    PH_DATA,
    PH_DESC,
    PH_DONE,
    PH_ERR
  } phase_t;

  localparam logic [31:0] OFS_SIG    = 32'd4;
  localparam logic [31:0] OFS_FLAGS  = 32'd8;
  localparam logic [31:0] OFS_METHOD = 32'd10;
  localparam logic [31:0] OFS_CSIZE  = 32'd22;
  localparam logic [31:0] OFS_USIZE  = 32'd26;
  localparam logic [31:0] OFS_NAME   = 32'd28;
  localparam logic [31:0] OFS_END    = 32'd30;
  localparam logic [4:0]  DESC_SIGNED   = 5'd16;
  localparam logic [4:0]  DESC_UNSIGNED = 5'd12;

  phase_t      phase_r, phase_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [15:0] flags_r, flags_nxt;
  logic [15:0] method_r, method_nxt;
  logic [31:0] csize_r, csize_nxt;
  logic [31:0] usize_r, usize_nxt;
  logic [15:0] fname_len_r, fname_len_nxt;
  logic [15:0] extra_len_r, extra_len_nxt;
  logic [4:0]  desc_len_r, desc_len_nxt;

  logic [31:0] cnt_inc;
  logic [31:0] shift_in;
  logic        is_defl;
  logic        has_desc;

  // skip empty runs in order: name, extra, payload, descriptor
  function automatic phase_t enter_phase(phase_t p, logic [15:0] fl, logic [15:0] el,
                                         logic [31:0] cs, logic dsc);
    phase_t q;
    q = p;
    if (q == PH_NAME && fl == 16'd0) q = PH_EXTRA;
    if (q == PH_EXTRA && el == 16'd0) q = PH_DATA;
    if (q == PH_DATA && cs == 32'd0) q = PH_DESC;
    if (q == PH_DESC && !dsc) q = PH_HDR;
    return q;
  endfunction

  assign cnt_inc  = cnt_r + 32'd1;
  assign shift_in = {data_byte_i, shift_r[31:8]};
  assign is_defl  = (method_r == zled_pkg::METHOD_DEFL);
  assign has_desc = flags_r[zled_pkg::FLAG_DESC_BIT];

  always_comb begin
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    shift_nxt     = shift_r;
    flags_nxt     = flags_r;
    method_nxt    = method_r;
    csize_nxt     = csize_r;
    usize_nxt     = usize_r;
    fname_len_nxt = fname_len_r;
    extra_len_nxt = extra_len_r;
    desc_len_nxt  = desc_len_r;
    res_o         = '0;

    if (take_i && phase_r != PH_DONE && phase_r != PH_ERR) begin
      if (stream_end_i) begin
        res_o.valid = 1'b1;
        if (phase_r == PH_HDR && cnt_r == 32'd0) begin
          phase_nxt  = PH_DONE;
          res_o.kind = zled_pkg::KIND_END;
        end else begin
          phase_nxt        = PH_ERR;
          res_o.kind       = zled_pkg::KIND_ERROR;
          res_o.error_code = zled_pkg::ERR_TRUNCATED;
        end
      end else begin
        case (phase_r)
          PH_HDR: begin
            shift_nxt = shift_in;
            cnt_nxt   = cnt_inc;
            case (cnt_inc)
              OFS_SIG: begin
                if (shift_in == zled_pkg::SIG_CENTRAL) begin
                  phase_nxt   = PH_DONE;
                  res_o.valid = 1'b1;
                  res_o.kind  = zled_pkg::KIND_END;
                end else if (shift_in != zled_pkg::SIG_LOCAL) begin
                  phase_nxt        = PH_ERR;
                  res_o.valid      = 1'b1;
                  res_o.kind       = zled_pkg::KIND_ERROR;
                  res_o.error_code = zled_pkg::ERR_SIGNATURE;
                end
              end
              OFS_FLAGS:  flags_nxt     = shift_in[31:16];
              OFS_METHOD: method_nxt    = shift_in[31:16];
              OFS_CSIZE:  csize_nxt     = shift_in;
              OFS_USIZE:  usize_nxt     = shift_in;
              OFS_NAME:   fname_len_nxt = shift_in[31:16];
              OFS_END: begin
                extra_len_nxt = shift_in[31:16];
                res_o.valid   = 1'b1;
                if (method_r != zled_pkg::METHOD_STORED && !is_defl) begin
                  phase_nxt        = PH_ERR;
                  res_o.kind       = zled_pkg::KIND_ERROR;
                  res_o.error_code = zled_pkg::ERR_METHOD;
                end else if (is_defl && has_desc) begin
                  phase_nxt        = PH_ERR;
                  res_o.kind       = zled_pkg::KIND_ERROR;
                  res_o.error_code = zled_pkg::ERR_DEFL_DESC;
                end else begin
                  res_o.kind          = zled_pkg::KIND_HEADER;
                  res_o.packed_size   = csize_r;
                  res_o.unpacked_size = usize_r;
                  res_o.is_deflate    = is_defl;
                  res_o.name_length   = fname_len_r;
                  phase_nxt    = enter_phase(PH_NAME, fname_len_r, shift_in[31:16],
                                             csize_r, has_desc);
                  cnt_nxt      = '0;
                  shift_nxt    = '0;
                  desc_len_nxt = '0;
                end
              end
              default: ;
            endcase
          end
          PH_NAME: begin
            cnt_nxt          = cnt_inc;
            res_o.valid      = 1'b1;
            res_o.kind       = zled_pkg::KIND_NAME;
            res_o.data       = data_byte_i;
            res_o.is_deflate = is_defl;
            if (cnt_inc >= {16'd0, fname_len_r}) begin
              res_o.last   = 1'b1;
              phase_nxt    = enter_phase(PH_EXTRA, fname_len_r, extra_len_r, csize_r,
                                         has_desc);
              cnt_nxt      = '0;
              shift_nxt    = '0;
              desc_len_nxt = '0;
            end
          end
          PH_EXTRA: begin
            cnt_nxt = cnt_inc;
            if (cnt_inc >= {16'd0, extra_len_r}) begin
              phase_nxt    = enter_phase(PH_DATA, fname_len_r, extra_len_r, csize_r,
                                         has_desc);
              cnt_nxt      = '0;
              shift_nxt    = '0;
              desc_len_nxt = '0;
            end
          end
          PH_DATA: begin
            cnt_nxt          = cnt_inc;
            res_o.valid      = 1'b1;
            res_o.kind       = zled_pkg::KIND_PAYLOAD;
            res_o.data       = data_byte_i;
            res_o.is_deflate = is_defl;
            if (cnt_inc >= csize_r) begin
              res_o.last   = 1'b1;
              phase_nxt    = enter_phase(PH_DESC, fname_len_r, extra_len_r, csize_r,
                                         has_desc);
              cnt_nxt      = '0;
              shift_nxt    = '0;
              desc_len_nxt = '0;
            end
          end
          PH_DESC: begin
            shift_nxt = shift_in;
            cnt_nxt   = cnt_inc;
            if (cnt_inc == OFS_SIG) begin
              desc_len_nxt = (shift_in == zled_pkg::SIG_DESC) ? DESC_SIGNED : DESC_UNSIGNED;
            end
            if (desc_len_nxt != 5'd0 && cnt_inc >= {27'd0, desc_len_nxt}) begin
              phase_nxt    = PH_HDR;
              cnt_nxt      = '0;
              shift_nxt    = '0;
              desc_len_nxt = '0;
            end
          end
          default: phase_nxt = PH_ERR;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HDR;
      cnt_r       <= '0;
      shift_r     <= '0;
      flags_r     <= '0;
      method_r    <= '0;
      csize_r     <= '0;
      usize_r     <= '0;
      fname_len_r <= '0;
      extra_len_r <= '0;
      desc_len_r  <= '0;
    end else begin
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      shift_r     <= shift_nxt;
      flags_r     <= flags_nxt;
      method_r    <= method_nxt;
      csize_r     <= csize_nxt;
      usize_r     <= usize_nxt;
      fname_len_r <= fname_len_nxt;
      extra_len_r <= extra_len_nxt;
      desc_len_r  <= desc_len_nxt;
    end
  end

`ifndef SYNTH
  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DONE |=> phase_r == PH_DONE)
    else $error("end of archive state left");
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_ERR |=> phase_r == PH_ERR)
    else $error("error state left");
  a_name_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_NAME |-> fname_len_r != 16'd0)
    else $error("empty filename run entered");
  a_desc_flagged: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DESC |-> has_desc && !is_defl)
    else $error("descriptor phase without stored entry flag");
  a_err_coded: assert property (@(posedge clk) disable iff (!rst_n)
    res_o.valid && res_o.kind == zled_pkg::KIND_ERROR |-> res_o.error_code != zled_pkg::ERR_NONE)
    else $error("error result without code");
`endif

endmodule

`default_nettype wire
